// ===== design/ple_pkg.sv =====
package ple_pkg;

  localparam int SEG_REGS   = 4;
  localparam int SEG_W      = 48;
  localparam int DUR_W      = 32;
  localparam int LVL_W      = 16;
  localparam int RATE_W     = 18;
  localparam int SEGCNT_W   = 3;
  localparam int START_W    = 32;
  localparam int COUNT_W    = 7;
  localparam int LEN_W      = 34;
  localparam int POS_W      = 36;
  localparam int T_W        = 33;
  localparam int QUO_W      = 17;
  localparam int DIVCNT_W   = 5;
  localparam int INDEX_W    = 3;

  localparam logic [COUNT_W-1:0]  MAX_RUN      = 7'd64;
  localparam logic [SEGCNT_W-1:0] MAX_SEGMENTS = 3'd4;
  localparam logic [RATE_W-1:0]   RATE_RESET   = 18'd48000;

  localparam logic [INDEX_W-1:0] REG_SEG0    = 3'd0;
  localparam logic [INDEX_W-1:0] REG_SEG1    = 3'd1;
  localparam logic [INDEX_W-1:0] REG_SEG2    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_SEG3    = 3'd3;
  localparam logic [INDEX_W-1:0] REG_SEGCNT  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_RATE    = 3'd5;

  typedef struct packed {
    logic [SEG_REGS-1:0][SEG_W-1:0] seg;
    logic [SEGCNT_W-1:0]            used;
    logic [RATE_W-1:0]              rate;
  } cfg_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [COUNT_W-1:0] count;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

// ===== design/ple_front.sv =====
module ple_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ple_pkg::START_W-1:0]  start_sample,
  input  logic [ple_pkg::COUNT_W-1:0]  sample_count,
  input  logic                         pop,
  output logic                         req_valid,
  output ple_pkg::req_t                req
);

  ple_pkg::req_t              q [2];
  logic                       wr_ptr;
  logic                       rd_ptr;
  logic [1:0]                 fill;
  logic                       accept;
  logic                       push;
  logic [ple_pkg::COUNT_W-1:0] count_sat;

  assign in_stall  = (fill == 2'd2);
  assign accept    = in_valid && !in_stall;
  // drop empty runs here, the back end never sees them
  assign push      = accept && (sample_count != '0);
  assign count_sat = (sample_count > ple_pkg::MAX_RUN) ? ple_pkg::MAX_RUN : sample_count;
  assign req_valid = (fill != 2'd0);
  assign req       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].start <= start_sample;
      q[wr_ptr].count <= count_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> fill != 2'd0)
    else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |=> fill != 2'd0)
    else $error("push did not land in queue");

endmodule

// ===== design/ple_back.sv =====
module ple_back (
  input  logic                        clk,
  input  logic                        rst,
  input  ple_pkg::cfg_t               cfg,
  input  logic                        req_valid,
  input  ple_pkg::req_t               req,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ple_pkg::LVL_W-1:0]   level,
  output logic                        last
);

  ple_pkg::state_t state, state_next;

  logic [ple_pkg::SEG_REGS-1:0][ple_pkg::LEN_W-1:0] len;
  logic [ple_pkg::SEGCNT_W-1:0]  k;
  logic [ple_pkg::SEGCNT_W-1:0]  used;
  logic [ple_pkg::T_W-1:0]       t;
  logic [ple_pkg::COUNT_W-1:0]   left;
  logic [ple_pkg::POS_W-1:0]     seg_start;
  logic signed [ple_pkg::LVL_W-1:0] prev;
  logic [ple_pkg::LEN_W-1:0]     off;
  logic signed [ple_pkg::QUO_W-1:0] diff;
  logic [ple_pkg::LEN_W-1:0]     div_len;
  logic signed [51:0]            prod;
  logic                          neg;
  logic [ple_pkg::LEN_W-1:0]     rem;
  logic [ple_pkg::QUO_W-1:0]     dq;
  logic [ple_pkg::DIVCNT_W-1:0]  divcnt;
  logic [ple_pkg::LVL_W-1:0]     result;

  logic [ple_pkg::LEN_W-1:0]     cur_len;
  logic signed [ple_pkg::LVL_W-1:0] cur_tgt;
  logic [ple_pkg::POS_W-1:0]     seg_end;
  logic                          hit;
  logic                          walk_done;
  logic [ple_pkg::DUR_W+ple_pkg::RATE_W-1:0] len_prod;
  logic [51:0]                   mag;
  logic [ple_pkg::LEN_W:0]       shifted;
  logic                          ge;
  logic [ple_pkg::QUO_W-1:0]     sum;
  logic                          load;

  assign used = (cfg.used > ple_pkg::MAX_SEGMENTS) ? ple_pkg::MAX_SEGMENTS : cfg.used;
  assign cur_len  = len[k[1:0]];
  assign cur_tgt  = $signed(cfg.seg[k[1:0]][ple_pkg::LVL_W-1:0]);
  assign seg_end  = seg_start + {2'b0, cur_len};
  assign walk_done = (k == used);
  assign hit      = !walk_done && (cur_len != '0) && ({3'b0, t} < seg_end);
  assign len_prod = cfg.seg[k[1:0]][ple_pkg::SEG_W-1:16] * cfg.rate;
  assign mag      = prod[51] ? 52'(-prod) : 52'(prod);
  assign shifted  = {rem, dq[ple_pkg::QUO_W-1]};
  assign ge       = shifted >= {1'b0, div_len};
  assign sum      = neg ? (17'(prev) - dq) : (17'(prev) + dq);

  always_comb begin
    state_next = state;
    case (state)
      ple_pkg::ST_IDLE: if (req_valid) state_next = ple_pkg::ST_LEN;
      ple_pkg::ST_LEN:  if (k == 3'd3) state_next = ple_pkg::ST_WALK;
      ple_pkg::ST_WALK: begin
        if (walk_done)  state_next = ple_pkg::ST_EMIT;
        else if (hit)   state_next = ple_pkg::ST_MUL;
      end
      ple_pkg::ST_MUL:  state_next = ple_pkg::ST_DIV;
      ple_pkg::ST_DIV:  if (divcnt == 5'(ple_pkg::QUO_W + 1)) state_next = ple_pkg::ST_EMIT;
      ple_pkg::ST_EMIT: begin
        if (load) state_next = (left == 7'd1) ? ple_pkg::ST_IDLE : ple_pkg::ST_WALK;
      end
      default: state_next = ple_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == ple_pkg::ST_IDLE) && req_valid;
    load = (state == ple_pkg::ST_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ple_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ple_pkg::ST_IDLE: begin
        t    <= {1'b0, req.start};
        left <= req.count;
        k    <= '0;
      end
      ple_pkg::ST_LEN: begin
        len[k[1:0]] <= len_prod[ple_pkg::DUR_W+ple_pkg::RATE_W-1:16];
        k <= (k == 3'd3) ? 3'd0 : k + 3'd1;
        seg_start <= '0;
        prev <= '0;
      end
      ple_pkg::ST_WALK: begin
        if (walk_done) begin
          result <= prev;
        end else if (hit) begin
          off     <= ple_pkg::LEN_W'({3'b0, t} - seg_start);
          diff    <= 17'(cur_tgt) - 17'(prev);
          div_len <= cur_len;
        end else begin
          seg_start <= seg_end;
          prev <= cur_tgt;
          k <= k + 3'd1;
        end
      end
      ple_pkg::ST_MUL: begin
        prod <= $signed({1'b0, off}) * diff;
      end
      ple_pkg::ST_DIV: begin
        if (divcnt == '0) begin
          // quotient fits 17 bits, so the top of the dividend is already a remainder
          neg <= prod[51];
          rem <= mag[50:17];
          dq  <= mag[16:0];
        end else if (divcnt != 5'(ple_pkg::QUO_W + 1)) begin
          rem <= ge ? ple_pkg::LEN_W'(shifted - {1'b0, div_len}) : shifted[ple_pkg::LEN_W-1:0];
          dq  <= {dq[ple_pkg::QUO_W-2:0], ge};
        end else begin
          result <= sum[ple_pkg::LVL_W-1:0];
        end
      end
      ple_pkg::ST_EMIT: begin
        if (load) begin
          left <= left - 7'd1;
          t    <= t + 33'd1;
          k    <= '0;
          seg_start <= '0;
          prev <= '0;
        end
      end
      default: ;
    endcase
  end

  // divide runs a setup step, 17 quotient steps and a final step to apply the sign
  always_ff @(posedge clk) begin
    if (rst) begin
      divcnt <= '0;
    end else if (state == ple_pkg::ST_DIV) begin
      divcnt <= (divcnt == 5'(ple_pkg::QUO_W + 1)) ? '0 : divcnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      level <= result;
      last  <= (left == 7'd1);
    end
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == ple_pkg::ST_WALK |-> k <= used)
    else $error("segment walk ran past used segments");
  a_load_shows: assert property (@(posedge clk) disable iff (rst) load |=> out_valid)
    else $error("loaded word not presented");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    divcnt <= 5'(ple_pkg::QUO_W + 1))
    else $error("divide counter overrun");

endmodule

// ===== design/piecewise_linear_envelope.sv =====
// Channel  | valid      | stall      | word
// request  | in_valid   | in_stall   | start_sample, sample_count
// level    | out_valid  | out_stall  | level, last
// config   | cfg_write  | (none)     | cfg_index, cfg_data
//
// Per request: a pop in IDLE, then segment-length multiplies for all 4 segment registers.
// Per level: a walk over the used segments, then on a ramp a multiply and a divide
// (setup, 17 restoring quotient steps, sign), then an emit step that out_stall can hold.
// Two requests queue in front of the engine; in_stall rises when both are taken.
// Output is a single register; out_stall holds the engine in its emit cycle.
// Reset (rst, synchronous) clears the queue, engine and segment registers.
module piecewise_linear_envelope (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ple_pkg::START_W-1:0]    start_sample,
  input  logic [ple_pkg::COUNT_W-1:0]    sample_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ple_pkg::LVL_W-1:0]      level,
  output logic                           last,
  input  logic                           cfg_write,
  input  logic [ple_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [ple_pkg::SEG_W-1:0]      cfg_data
);

  ple_pkg::cfg_t cfg;
  ple_pkg::req_t req;
  logic          req_valid;
  logic          pop;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seg  <= '0;
      cfg.used <= '0;
      cfg.rate <= ple_pkg::RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ple_pkg::REG_SEG0:   cfg.seg[0] <= cfg_data;
        ple_pkg::REG_SEG1:   cfg.seg[1] <= cfg_data;
        ple_pkg::REG_SEG2:   cfg.seg[2] <= cfg_data;
        ple_pkg::REG_SEG3:   cfg.seg[3] <= cfg_data;
        ple_pkg::REG_SEGCNT: cfg.used <= cfg_data[ple_pkg::SEGCNT_W-1:0];
        ple_pkg::REG_RATE:   cfg.rate <= cfg_data[ple_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  ple_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_sample (start_sample),
    .sample_count (sample_count),
    .pop          (pop),
    .req_valid    (req_valid),
    .req          (req)
  );

  ple_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level),
    .last      (last)
  );

endmodule
